// ===== rtl/c0bl_pkg.sv =====
// Shared types, token kinds and keyword tables for the C0 byte lexer.
`default_nettype none

package c0bl_pkg;

    localparam int KEYWORD_COUNT = 13;
    localparam logic [2:0] POS_MAX = 3'd7;

    // Token kinds
    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_INTCON  = 6'd1;
    localparam logic [5:0] K_CHARCON = 6'd2;
    localparam logic [5:0] K_STRCON  = 6'd3;
    localparam logic [5:0] K_KW0     = 6'd4;
    localparam logic [5:0] K_PLUS    = 6'd17;
    localparam logic [5:0] K_MINU    = 6'd18;
    localparam logic [5:0] K_MULT    = 6'd19;
    localparam logic [5:0] K_DIV     = 6'd20;
    localparam logic [5:0] K_LSS     = 6'd21;
    localparam logic [5:0] K_LEQ     = 6'd22;
    localparam logic [5:0] K_GRE     = 6'd23;
    localparam logic [5:0] K_GEQ     = 6'd24;
    localparam logic [5:0] K_EQL     = 6'd25;
    localparam logic [5:0] K_NEQ     = 6'd26;
    localparam logic [5:0] K_ASSIGN  = 6'd27;
    localparam logic [5:0] K_SEMICN  = 6'd28;
    localparam logic [5:0] K_COMMA   = 6'd29;
    localparam logic [5:0] K_LPARENT = 6'd30;
    localparam logic [5:0] K_RPARENT = 6'd31;
    localparam logic [5:0] K_LBRACK  = 6'd32;
    localparam logic [5:0] K_RBRACK  = 6'd33;
    localparam logic [5:0] K_LBRACE  = 6'd34;
    localparam logic [5:0] K_RBRACE  = 6'd35;

    // Keyword text, right-aligned: first character sits at byte (len - 1)
    localparam logic [47:0] KW_TEXT [KEYWORD_COUNT] = '{
        48'("const"), 48'("int"), 48'("char"), 48'("void"), 48'("main"),
        48'("if"), 48'("else"), 48'("do"), 48'("while"), 48'("for"),
        48'("scanf"), 48'("printf"), 48'("return")
    };
    localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
        3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
    };

    // One result record as the lexer produces it
    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] text;
        logic       present;
        logic       done;
        logic       bad;
    } t_res;

    // Results of one request, handed from the lexer to the result queue
    typedef struct packed {
        logic [1:0]  count;
        t_res        first;
        t_res        second;
        logic [15:0] lines;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/c0bl_lexer.sv =====
// Lexer state registers and the single-pass decode of one source byte.
`default_nettype none

module c0bl_lexer
    import c0bl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eot,
    output t_push           o_push
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_CHAR_OPEN, M_CHAR_CLOSE,
        M_STRING, M_LT, M_GT, M_EQ, M_BANG
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [KEYWORD_COUNT-1:0] r_cand, n_cand;
    logic [2:0]               r_pos,  n_pos;
    logic [15:0]              r_lines, n_lines;

    // Start-of-token decode
    t_mode                    s_mode;
    logic                     s_emit, s_nl, s_kw;
    t_res                     s_res;
    logic [KEYWORD_COUNT-1:0] s_cand, a_cand;
    logic [2:0]               a_pos;
    logic [5:0]               id_kind;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic t_res mk(input logic [5:0] kind, input logic [7:0] text,
                                input logic present, input logic done, input logic bad);
        t_res r;
        r.kind    = done ? kind : 6'd0;
        r.text    = present ? text : 8'd0;
        r.present = present;
        r.done    = done;
        r.bad     = bad;
        return r;
    endfunction

    // Drop candidates whose character at this position differs or is absent; at POS_MAX drop all
    function automatic logic [KEYWORD_COUNT-1:0] kw_mask(
        input logic [KEYWORD_COUNT-1:0] cand, input logic [2:0] pos, input logic [7:0] b);
        logic [KEYWORD_COUNT-1:0] m;
        int                       sh;
        m = cand;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            sh = (pos < KW_LEN[k]) ? 8 * (int'(KW_LEN[k]) - 1 - int'(pos)) : 0;
            if (!(pos < KW_LEN[k] && KW_TEXT[k][sh +: 8] == b)) begin
                m[k] = 1'b0;
            end
        end
        if (pos == POS_MAX) begin
            m = '0;
        end
        return m;
    endfunction

    // Keyword advance on the current identifier
    always_comb begin
        a_cand = kw_mask(r_cand, r_pos, i_byte);
        a_pos  = (r_pos == POS_MAX) ? POS_MAX : r_pos + 3'd1;
        s_cand = kw_mask({KEYWORD_COUNT{1'b1}}, 3'd0, i_byte);
    end

    // Kind of the identifier ending now
    always_comb begin
        id_kind = K_IDENT;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (r_cand[k] && r_pos == KW_LEN[k]) begin
                id_kind = K_KW0 + 6'(k);
            end
        end
    end

    // Byte seen from idle
    always_comb begin
        s_mode = M_IDLE;
        s_emit = 1'b0;
        s_nl   = 1'b0;
        s_kw   = 1'b0;
        s_res  = '0;
        priority if (i_byte == " " || i_byte == 8'h0d || i_byte == 8'h09
                     || i_byte == 8'h0a) begin
            s_nl = (i_byte == 8'h0a);
        end else if (is_letter(i_byte)) begin
            s_kw   = 1'b1;
            s_emit = 1'b1;
            s_res  = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0);
            s_mode = M_IDENT;
        end else if (is_digit(i_byte)) begin
            s_emit = 1'b1;
            s_res  = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0);
            s_mode = M_INT;
        end else begin
            s_emit = 1'b1;
            unique case (i_byte)
                "'":  begin s_emit = 1'b0; s_mode = M_CHAR_OPEN; end
                "\"": begin s_emit = 1'b0; s_mode = M_STRING; end
                "<":  begin s_mode = M_LT;   s_res = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0); end
                ">":  begin s_mode = M_GT;   s_res = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0); end
                "=":  begin s_mode = M_EQ;   s_res = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0); end
                "!":  begin s_mode = M_BANG; s_res = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0); end
                "+":  s_res = mk(K_PLUS,    i_byte, 1'b1, 1'b1, 1'b0);
                "-":  s_res = mk(K_MINU,    i_byte, 1'b1, 1'b1, 1'b0);
                "*":  s_res = mk(K_MULT,    i_byte, 1'b1, 1'b1, 1'b0);
                "/":  s_res = mk(K_DIV,     i_byte, 1'b1, 1'b1, 1'b0);
                ";":  s_res = mk(K_SEMICN,  i_byte, 1'b1, 1'b1, 1'b0);
                ",":  s_res = mk(K_COMMA,   i_byte, 1'b1, 1'b1, 1'b0);
                "(":  s_res = mk(K_LPARENT, i_byte, 1'b1, 1'b1, 1'b0);
                ")":  s_res = mk(K_RPARENT, i_byte, 1'b1, 1'b1, 1'b0);
                "[":  s_res = mk(K_LBRACK,  i_byte, 1'b1, 1'b1, 1'b0);
                "]":  s_res = mk(K_RBRACK,  i_byte, 1'b1, 1'b1, 1'b0);
                "{":  s_res = mk(K_LBRACE,  i_byte, 1'b1, 1'b1, 1'b0);
                "}":  s_res = mk(K_RBRACE,  i_byte, 1'b1, 1'b1, 1'b0);
                default: s_res = mk(6'd0, 8'd0, 1'b0, 1'b0, 1'b1);
            endcase
        end
    end

    // Main decode: results and next state for this request
    always_comb begin
        logic       use_start;
        logic       ok;
        logic [1:0] cnt;
        t_res       first, second;
        use_start = 1'b0;
        ok        = 1'b0;
        cnt       = 2'd0;
        first     = '0;
        second    = '0;
        n_mode    = r_mode;
        n_cand    = r_cand;
        n_pos     = r_pos;

        if (i_eot) begin
            cnt = 2'd1;
            unique case (r_mode)
                M_IDENT:     first = mk(id_kind,   8'd0, 1'b0, 1'b1, 1'b0);
                M_INT:       first = mk(K_INTCON,  8'd0, 1'b0, 1'b1, 1'b0);
                M_CHAR_OPEN: first = mk(K_CHARCON, 8'd0, 1'b0, 1'b1, 1'b0);
                M_STRING:    first = mk(K_STRCON,  8'd0, 1'b0, 1'b1, 1'b0);
                M_LT:        first = mk(K_LSS,     8'd0, 1'b0, 1'b1, 1'b0);
                M_GT:        first = mk(K_GRE,     8'd0, 1'b0, 1'b1, 1'b0);
                M_EQ:        first = mk(K_ASSIGN,  8'd0, 1'b0, 1'b1, 1'b0);
                M_BANG:      first = mk(K_NEQ,     8'd0, 1'b0, 1'b1, 1'b0);
                default:     cnt = 2'd0;
            endcase
            n_mode = M_IDLE;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_letter(i_byte) || is_digit(i_byte)) begin
                        n_cand = a_cand;
                        n_pos  = a_pos;
                        first  = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0);
                        cnt    = 2'd1;
                    end else begin
                        first     = mk(id_kind, 8'd0, 1'b0, 1'b1, 1'b0);
                        cnt       = 2'd1;
                        use_start = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit(i_byte)) begin
                        first = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0);
                    end else begin
                        first     = mk(K_INTCON, 8'd0, 1'b0, 1'b1, 1'b0);
                        use_start = 1'b1;
                    end
                    cnt = 2'd1;
                end
                M_CHAR_OPEN: begin
                    ok = is_letter(i_byte) || is_digit(i_byte) || i_byte == "+"
                         || i_byte == "-" || i_byte == "*" || i_byte == "/";
                    first  = mk(K_CHARCON, i_byte, 1'b1, 1'b1, !ok);
                    cnt    = 2'd1;
                    n_mode = M_CHAR_CLOSE;
                end
                M_CHAR_CLOSE: n_mode = M_IDLE;
                M_STRING: begin
                    if (i_byte == "\"") begin
                        first  = mk(K_STRCON, 8'd0, 1'b0, 1'b1, 1'b0);
                        cnt    = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        ok = i_byte == 8'd32 || i_byte == 8'd33
                             || (i_byte >= 8'd35 && i_byte <= 8'd126);
                        if (i_byte == "\\") begin
                            // backslash is doubled
                            first  = mk(6'd0, i_byte, 1'b1, 1'b0, 1'b0);
                            second = mk(6'd0, i_byte, 1'b1, 1'b0, !ok);
                            cnt    = 2'd2;
                        end else begin
                            first = mk(6'd0, i_byte, 1'b1, 1'b0, !ok);
                            cnt   = 2'd1;
                        end
                    end
                end
                M_LT, M_GT, M_EQ: begin
                    cnt = 2'd1;
                    if (i_byte == "=") begin
                        first = mk((r_mode == M_LT) ? K_LEQ : ((r_mode == M_GT) ? K_GEQ : K_EQL),
                                   i_byte, 1'b1, 1'b1, 1'b0);
                        n_mode = M_IDLE;
                    end else begin
                        first = mk((r_mode == M_LT) ? K_LSS :
                                   ((r_mode == M_GT) ? K_GRE : K_ASSIGN),
                                   8'd0, 1'b0, 1'b1, 1'b0);
                        use_start = 1'b1;
                    end
                end
                M_BANG: begin
                    first  = mk(K_NEQ, i_byte, 1'b1, 1'b1, 1'b0);
                    cnt    = 2'd1;
                    n_mode = M_IDLE;
                end
                default: use_start = 1'b1;
            endcase
        end

        // Byte handled from idle, after any token it closed
        if (use_start) begin
            n_mode = s_mode;
            if (s_kw) begin
                n_cand = s_cand;
                n_pos  = 3'd1;
            end
            if (s_emit) begin
                if (cnt == 2'd1) begin
                    second = s_res;
                end else begin
                    first = s_res;
                end
                cnt = cnt + 2'd1;
            end
        end

        n_lines = (use_start && s_nl && r_lines != 16'hFFFF) ? r_lines + 16'd1 : r_lines;

        o_push.count  = cnt;
        o_push.first  = first;
        o_push.second = second;
        o_push.lines  = n_lines;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_cand  <= {KEYWORD_COUNT{1'b1}};
            r_pos   <= 3'd0;
            r_lines <= 16'd0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_cand  <= n_cand;
            r_pos   <= n_pos;
            r_lines <= n_lines;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/c0bl_resq.sv =====
// Four-entry result queue: takes up to two results a cycle, gives one while i_ready is high.
`default_nettype none

module c0bl_resq
    import c0bl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire t_push       i_push,
    output logic             o_wr_ready,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [5:0]       o_kind,
    output logic [7:0]       o_text,
    output logic             o_present,
    output logic             o_done,
    output logic             o_bad,
    output logic [15:0]      o_lines,
    output logic             o_last
);

    typedef struct packed {
        t_res        res;
        logic [15:0] lines;
        logic        last;
    } t_entry;

    t_entry      r_mem [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic [1:0]  wr_n;
    logic        pop;
    t_entry      e0, e1, head;

    // Room for the largest request
    assign o_wr_ready = (r_cnt < 3'd3);
    assign o_valid    = (r_cnt != 3'd0);
    assign pop        = o_valid && i_ready;
    assign wr_n       = i_wr ? i_push.count : 2'd0;

    always_comb begin
        e0.res   = i_push.first;
        e0.lines = i_push.lines;
        e0.last  = (i_push.count == 2'd1);
        e1.res   = i_push.second;
        e1.lines = i_push.lines;
        e1.last  = 1'b1;
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (wr_n != 2'd0) begin
            r_mem[r_wp] <= e0;
        end
        if (wr_n == 2'd2) begin
            r_mem[r_wp + 2'd1] <= e1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + wr_n;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, wr_n} - {2'b0, pop};
        end
    end

    assign head      = r_mem[r_rp];
    assign o_kind    = head.res.kind;
    assign o_text    = head.res.text;
    assign o_present = head.res.present;
    assign o_done    = head.res.done;
    assign o_bad     = head.res.bad;
    assign o_lines   = head.lines;
    assign o_last    = head.last;

endmodule

`default_nettype wire

// ===== rtl/c0_byte_lexer_core.sv =====
// Top level of the C0 byte lexer: lexer decode feeding the result queue.
//
//  channel  valid    ready    payload
//  source   i_valid  o_ready  i_source_byte, i_end_of_text
//  tokens   o_valid  i_ready  o_token_kind, o_text_byte, o_text_present,
//                             o_token_done, o_bad_char, o_line_count, o_last_of_run
//
// One source byte per cycle while o_ready is high; its results are registered into the queue.
// A request yields zero, one or two results; the queue drains one per cycle while
// i_ready is high, so bytes giving two results hold the source side back at that rate.
// o_ready is high while the four-entry queue has room for two results.
// Synchronous reset returns to idle with a zero line count.
`default_nettype none

module c0_byte_lexer_core
    import c0bl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [5:0]       o_token_kind,
    output logic [7:0]       o_text_byte,
    output logic             o_text_present,
    output logic             o_token_done,
    output logic             o_bad_char,
    output logic [15:0]      o_line_count,
    output logic             o_last_of_run
);

    t_push push;
    logic  take;

    assign take = i_valid && o_ready;

    c0bl_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_source_byte),
        .i_eot   (i_end_of_text),
        .o_push  (push)
    );

    c0bl_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (take),
        .i_push     (push),
        .o_wr_ready (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_token_kind),
        .o_text     (o_text_byte),
        .o_present  (o_text_present),
        .o_done     (o_token_done),
        .o_bad      (o_bad_char),
        .o_lines    (o_line_count),
        .o_last     (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== bench/c0_byte_lexer_core_tb.sv =====
// Self-checking testbench for c0_byte_lexer_core: directed and random text, scoreboarded.
`default_nettype none

module c0_byte_lexer_core_tb;
    import c0bl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 10;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        LX_IDLE, LX_IDENT, LX_INT, LX_CHAR_OPEN, LX_CHAR_CLOSE,
        LX_STRING, LX_LT, LX_GT, LX_EQ, LX_BANG
    } lex_mode_e;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  text;
        logic        present;
        logic        done;
        logic        bad;
        logic [15:0] lines;
        logic        last;
    } lex_result_t;

    // Token predictor plus queue of token results still owed by the core
    class lexer_scoreboard;
        lex_result_t token_q[$];
        lex_result_t step_q[$];
        lex_mode_e   mode;
        logic [12:0] kw_cand;
        int unsigned kw_pos;
        logic [15:0] newlines;
        int unsigned errors;
        string       kw_word[KEYWORD_COUNT];

        function new();
            kw_word = '{"const", "int", "char", "void", "main", "if", "else",
                        "do", "while", "for", "scanf", "printf", "return"};
            mode     = LX_IDLE;
            kw_cand  = '1;
            kw_pos   = 0;
            newlines = '0;
            errors   = 0;
        endfunction

        function int unsigned pending();
            return token_q.size();
        endfunction

        function bit is_word_lead(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function void add(logic [5:0] kind, logic [7:0] b, bit present, bit done, bit bad);
            lex_result_t r;
            r         = '0;
            r.kind    = done ? kind : 6'd0;
            r.text    = present ? b : 8'd0;
            r.present = present;
            r.done    = done;
            r.bad     = bad;
            step_q.push_back(r);
        endfunction

        // Drop keywords that disagree at the current position
        function void match_keyword(logic [7:0] b);
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                if (kw_pos >= kw_word[k].len() || kw_word[k][kw_pos] != b)
                    kw_cand[k] = 1'b0;
            end
            if (kw_pos < 7) kw_pos++;
            else kw_cand = '0;
        endfunction

        function logic [5:0] ident_kind();
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                if (kw_cand[k] && kw_pos == kw_word[k].len())
                    return K_KW0 + 6'(k);
            end
            return K_IDENT;
        endfunction

        function logic [5:0] pending_op();
            if (mode == LX_LT) return K_LSS;
            if (mode == LX_GT) return K_GRE;
            return K_ASSIGN;
        endfunction

        // A byte seen between tokens
        function void open_token(logic [7:0] b);
            logic [5:0] single;
            single = '0;
            mode   = LX_IDLE;
            if (b == CH_SPACE || b == CH_CR || b == CH_TAB || b == CH_LF) begin
                if (b == CH_LF && newlines != 16'hFFFF) newlines++;
                return;
            end
            if (is_word_lead(b)) begin
                kw_cand = '1;
                kw_pos  = 0;
                match_keyword(b);
                add(K_IDENT, b, 1, 0, 0);
                mode = LX_IDENT;
                return;
            end
            if (is_digit(b)) begin
                add(K_IDENT, b, 1, 0, 0);
                mode = LX_INT;
                return;
            end
            case (b)
                CH_SQUOTE: begin mode = LX_CHAR_OPEN; return; end
                CH_DQUOTE: begin mode = LX_STRING; return; end
                "<": mode = LX_LT;
                ">": mode = LX_GT;
                "=": mode = LX_EQ;
                "!": mode = LX_BANG;
                "+": single = K_PLUS;
                "-": single = K_MINU;
                "*": single = K_MULT;
                "/": single = K_DIV;
                ";": single = K_SEMICN;
                ",": single = K_COMMA;
                "(": single = K_LPARENT;
                ")": single = K_RPARENT;
                "[": single = K_LBRACK;
                "]": single = K_RBRACK;
                "{": single = K_LBRACE;
                "}": single = K_RBRACE;
                default: begin
                    add(K_IDENT, 8'd0, 0, 0, 1);
                    return;
                end
            endcase
            if (single != '0) add(single, b, 1, 1, 0);
            else add(K_IDENT, b, 1, 0, 0);
        endfunction

        // Accepted request: work out the token results it owes
        function void note(logic [7:0] b, logic eot);
            bit ok;
            step_q.delete();
            if (eot) begin
                case (mode)
                    LX_IDENT:     add(ident_kind(), 8'd0, 0, 1, 0);
                    LX_INT:       add(K_INTCON, 8'd0, 0, 1, 0);
                    LX_CHAR_OPEN: add(K_CHARCON, 8'd0, 0, 1, 0);
                    LX_STRING:    add(K_STRCON, 8'd0, 0, 1, 0);
                    LX_LT, LX_GT, LX_EQ: add(pending_op(), 8'd0, 0, 1, 0);
                    LX_BANG:      add(K_NEQ, 8'd0, 0, 1, 0);
                    default: ;
                endcase
                mode = LX_IDLE;
            end else begin
                case (mode)
                    LX_IDENT: begin
                        if (is_word_lead(b) || is_digit(b)) begin
                            match_keyword(b);
                            add(K_IDENT, b, 1, 0, 0);
                        end else begin
                            add(ident_kind(), 8'd0, 0, 1, 0);
                            open_token(b);
                        end
                    end
                    LX_INT: begin
                        if (is_digit(b)) begin
                            add(K_IDENT, b, 1, 0, 0);
                        end else begin
                            add(K_INTCON, 8'd0, 0, 1, 0);
                            open_token(b);
                        end
                    end
                    LX_CHAR_OPEN: begin
                        ok = is_word_lead(b) || is_digit(b) || b == "+" || b == "-" ||
                             b == "*" || b == "/";
                        add(K_CHARCON, b, 1, 1, !ok);
                        mode = LX_CHAR_CLOSE;
                    end
                    // closing quote is swallowed whatever it is
                    LX_CHAR_CLOSE: mode = LX_IDLE;
                    LX_STRING: begin
                        if (b == CH_DQUOTE) begin
                            add(K_STRCON, 8'd0, 0, 1, 0);
                            mode = LX_IDLE;
                        end else begin
                            ok = b == 8'd32 || b == 8'd33 || (b >= 8'd35 && b <= 8'd126);
                            if (b == CH_BSLASH) add(K_IDENT, CH_BSLASH, 1, 0, 0);
                            add(K_IDENT, b, 1, 0, !ok);
                        end
                    end
                    LX_LT, LX_GT, LX_EQ: begin
                        if (b == "=") begin
                            add(mode == LX_LT ? K_LEQ : (mode == LX_GT ? K_GEQ : K_EQL),
                                b, 1, 1, 0);
                            mode = LX_IDLE;
                        end else begin
                            add(pending_op(), 8'd0, 0, 1, 0);
                            open_token(b);
                        end
                    end
                    LX_BANG: begin
                        add(K_NEQ, b, 1, 1, 0);
                        mode = LX_IDLE;
                    end
                    default: open_token(b);
                endcase
            end
            // line count is taken after the whole request
            foreach (step_q[i]) begin
                step_q[i].lines = newlines;
                step_q[i].last  = (i == step_q.size() - 1);
                token_q.push_back(step_q[i]);
            end
        endfunction

        function void check(lex_result_t got);
            lex_result_t want;
            if (token_q.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected token result kind=%0d text=%02h", $time,
                             got.kind, got.text);
                errors++;
                return;
            end
            want = token_q.pop_front();
            if (got !== want) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t: mismatch exp kind=%0d text=%02h pres=%b done=%b bad=%b",
                             $time, want.kind, want.text, want.present, want.done, want.bad);
                    $display("    lines=%0d last=%b | got kind=%0d text=%02h pres=%b done=%b",
                             want.lines, want.last, got.kind, got.text, got.present,
                             got.done);
                    $display("    bad=%b lines=%0d last=%b", got.bad, got.lines, got.last);
                end
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_source_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_token_kind;
    logic [7:0]  o_text_byte;
    logic        o_text_present;
    logic        o_token_done;
    logic        o_bad_char;
    logic [15:0] o_line_count;
    logic        o_last_of_run;

    lexer_scoreboard sb;
    int unsigned     src_idle_pct;
    int unsigned     rx_idle_pct;
    int unsigned     hold_reqs;
    int unsigned     items_sent;
    int unsigned     cycle_count;

    c0_byte_lexer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_source_byte  (i_source_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_text_byte    (o_text_byte),
        .o_text_present (o_text_present),
        .o_token_done   (o_token_done),
        .o_bad_char     (o_bad_char),
        .o_line_count   (o_line_count),
        .o_last_of_run  (o_last_of_run)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested
    initial begin : token_sink
        int unsigned hold_left;
        int unsigned hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_ready     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_reqs) begin
                hold_served = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                i_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin : handshake_monitor
        lex_result_t got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.kind    = o_token_kind;
                got.text    = o_text_byte;
                got.present = o_text_present;
                got.done    = o_token_done;
                got.bad     = o_bad_char;
                got.lines   = o_line_count;
                got.last    = o_last_of_run;
                sb.check(got);
            end
            if (i_valid && o_ready)
                sb.note(i_source_byte, i_end_of_text);
        end
    end

    // One source request; called and returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_source_byte = b;
        i_end_of_text = eot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    // Sender stops and waits for every owed token result
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        int unsigned r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic string op_word(input int unsigned i);
        case (i)
            0: return "+";    1: return "-";    2: return "*";    3: return "/";
            4: return "<";    5: return "<=";   6: return ">";    7: return ">=";
            8: return "==";   9: return "!=";   10: return "=";   11: return ";";
            12: return ",";   13: return "(";   14: return ")";   15: return "[";
            16: return "]";   17: return "{";
            default: return "}";
        endcase
    endfunction

    // Usually closes an identifier or number so keywords get resolved
    task automatic send_separator();
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 6))
                0: send_item(CH_SPACE, 1'b0);
                1: send_item(CH_LF, 1'b0);
                2: send_item(";", 1'b0);
                3: send_item("(", 1'b0);
                4: send_item(",", 1'b0);
                5: send_item("=", 1'b0);
                default: send_item("<", 1'b0);
            endcase
        end
    endtask

    // One random token, well formed most of the time
    task automatic send_token();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        string       w;
        logic [7:0]  c;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1, 2: begin
                // keyword, sometimes cut short, extended or with its lead case flipped
                k = $urandom_range(0, KEYWORD_COUNT - 1);
                w = sb.kw_word[k];
                n = $urandom_range(0, 5);
                if (n == 0) w = w.substr(0, $urandom_range(0, w.len() - 2));
                if (n == 2) begin
                    send_item(w[0] ^ 8'h20, 1'b0);
                    if (w.len() > 1) send_text(w.substr(1, w.len() - 1));
                end else begin
                    send_text(w);
                end
                if (n == 1) send_item(word_char(1'b0), 1'b0);
                send_separator();
            end
            3, 4: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 4);
                send_item(word_char(1'b1), 1'b0);
                repeat (n - 1) send_item(word_char(1'b0), 1'b0);
                send_separator();
            end
            5: begin
                repeat ($urandom_range(1, 6)) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                send_separator();
            end
            6: begin
                send_item(CH_SQUOTE, 1'b0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: c = word_char(1'b0);
                    5, 6: c = op_word($urandom_range(0, 3)).getc(0);
                    default: c = 8'($urandom_range(0, 255));
                endcase
                send_item(c, 1'b0);
                if ($urandom_range(0, 9) < 8) send_item(CH_SQUOTE, 1'b0);
                else send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            7: begin
                send_item(CH_DQUOTE, 1'b0);
                repeat ($urandom_range(0, 8)) begin
                    n = $urandom_range(0, 19);
                    if (n < 12) c = 8'($urandom_range(32, 126));
                    else if (n < 15) c = CH_BSLASH;
                    else c = 8'($urandom_range(0, 255));
                    if (c == CH_DQUOTE) c = 8'd35;
                    send_item(c, 1'b0);
                end
                if ($urandom_range(0, 9) != 0) send_item(CH_DQUOTE, 1'b0);
            end
            8, 9, 10, 11: begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item("!", 1'b0);
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end else begin
                    send_text(op_word($urandom_range(0, 18)));
                end
            end
            12, 13, 14: begin
                case ($urandom_range(0, 3))
                    0: send_item(CH_SPACE, 1'b0);
                    1: send_item(CH_CR, 1'b0);
                    2: send_item(CH_TAB, 1'b0);
                    default: send_item(CH_LF, 1'b0);
                endcase
            end
            15: send_item(8'($urandom_range(0, 255)), 1'b0);
            16: send_item(8'($urandom_range(0, 255)), 1'b1);
            default: send_item(8'($urandom_range(32, 126)), 1'b0);
        endcase
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_source_byte = 8'd0;
        i_end_of_text = 1'b0;
        src_idle_pct  = 36;
        rx_idle_pct   = 68;
        hold_reqs     = 0;
        items_sent    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: keyword, char literals, string escapes, compound ops, flushes
        send_text("while");
        send_item(CH_SQUOTE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item("x", 1'b0);
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(CH_DQUOTE, 1'b0);
        send_text("<=");
        send_item("!", 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item("7", 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(">", 1'b0);
        send_item(8'h00, 1'b1);
        send_text("Int ");

        // Sender sparse-ish, receiver stalls often
        while (items_sent < 120) send_token();
        drain();

        // Sender idles more; long receiver hold-off fills the core first
        src_idle_pct = 68;
        rx_idle_pct  = 36;
        hold_reqs++;
        repeat (30) send_token();
        while (items_sent < 220) send_token();
        drain();

        // Full rate both ways
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        while (items_sent < 320) send_token();
        repeat (10) send_token();
        drain();

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
